// ===== hw/rtl/gdfw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared sizes, codes and controller/datapath signal groups for the
// depth-first graph walker.
// ----------------------------------------------------------------------------
package gdfw_pkg;

  // graph sizing
  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;

  localparam int VTX_W   = $clog2(MAX_VERTICES);       // vertex id
  localparam int SLOT_W  = $clog2(MAX_DEGREE);         // slot within one list
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);     // list length, also next index
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);   // stack depth
  localparam int CFG_W   = 7;                          // vertex_count register
  localparam int STAT_W  = 3;

  localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int STK_W     = VTX_W + DEG_W + DEG_W;    // vertex, next index, degree

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED = 3'd0,
    STAT_RANGE = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_VISIT = 3'd3,
    STAT_START = 3'd4
  } gdfw_status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_E_RDB,
    S_E_CHK,
    S_E_WRA,
    S_E_WRB,
    S_RESP,
    S_W_DEG,
    S_W_STEP,
    S_W_NBR,
    S_W_POP,
    S_W_FLUSH
  } gdfw_state_t;

  // degree memory read address select
  typedef enum logic [1:0] {
    DSEL_A,
    DSEL_B,
    DSEL_X
  } gdfw_dsel_t;

  // controller to datapath
  typedef struct packed {
    logic         accept;
    logic         deg_rd;
    gdfw_dsel_t   deg_sel;
    logic         lat_deg_a;
    logic         lat_deg_b;
    logic         lat_top_deg;
    logic         edge_wr_a;
    logic         edge_wr_b;
    logic         code_ld;
    gdfw_status_t code;
    logic         walk_init;
    logic         nbr_rd;
    logic         push;
    logic         pop;
    logic         pop_load;
    logic         emit_status;
    logic         emit_final;
  } gdfw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_walk;
    logic a_ok;
    logic ab_ok;
    logic fits;
    logic has_next;
    logic push_ok;
    logic depth_one;
    logic out_free;
  } gdfw_sts_t;

endpackage

// ===== hw/rtl/gdfw_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw channel interfaces
// Request and result channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface gdfw_in_if;
  import gdfw_pkg::*;

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, output req_type, output vertex_a, output vertex_b,
                  input ready);
  modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                  output ready);
endinterface

interface gdfw_out_if;
  import gdfw_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VTX_W-1:0]  visited_vertex;
  logic              last;

  modport source (output valid, output status, output visited_vertex, output last,
                  input ready);
  modport sink   (input valid, input status, input visited_vertex, input last,
                  output ready);
endinterface

// ===== hw/rtl/graph_depth_first_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_depth_first_walk
// Stores an undirected graph as per-vertex neighbor lists and emits the
// depth-first preorder from a start vertex.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid/ready     req_type, vertex_a, vertex_b
//   out_ch    out  valid/ready     status, visited_vertex, last
//   cfg       in   cfg_we          cfg_wdata (vertex_count)
//
// One request at a time, the next taken once the result is registered. An
// add-edge request passes decode, both degree reads, the fit check and both
// list writes to its response (full list or range fail respond early); the
// degree memory is read once per endpoint. A walk reads the degree and pops
// the stack per visited vertex and reads the neighbor memory per entry
// scanned, all reads registered. A stalled result register holds the walk.
// Synchronous active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_depth_first_walk (
  input  logic                       clk,
  input  logic                       rst_n,
  gdfw_in_if.sink                    in_ch,
  gdfw_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [gdfw_pkg::CFG_W-1:0] cfg_wdata
);
  import gdfw_pkg::*;

  gdfw_cmd_t    cmd;
  gdfw_sts_t    sts;
  gdfw_status_t out_status;

  // controller
  gdfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  gdfw_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_ch.req_type),
    .in_vertex_a (in_ch.vertex_a),
    .in_vertex_b (in_ch.vertex_b),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_status),
    .out_vertex  (out_ch.visited_vertex),
    .out_last    (out_ch.last)
  );

  assign out_ch.status = out_status;

endmodule

// ===== hw/rtl/gdfw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/gdfw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Controller state machine: sequences edge insertion and the stack walk.
// ----------------------------------------------------------------------------
module gdfw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gdfw_pkg::gdfw_sts_t sts,
  output gdfw_pkg::gdfw_cmd_t cmd
);
  import gdfw_pkg::*;

  gdfw_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.deg_sel = DSEL_A;
    cmd.code    = STAT_ADDED;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_walk) begin
          if (!sts.a_ok) begin
            cmd.code_ld = 1'b1;
            cmd.code    = STAT_START;
            state_nxt   = S_RESP;
          end else begin
            cmd.walk_init = 1'b1;
            cmd.deg_rd    = 1'b1;
            cmd.deg_sel   = DSEL_A;
            state_nxt     = S_W_DEG;
          end
        end else if (!sts.ab_ok) begin
          cmd.code_ld = 1'b1;
          cmd.code    = STAT_RANGE;
          state_nxt   = S_RESP;
        end else begin
          cmd.deg_rd  = 1'b1;
          cmd.deg_sel = DSEL_A;
          state_nxt   = S_E_RDB;
        end
      end
      S_E_RDB: begin
        cmd.lat_deg_a = 1'b1;
        cmd.deg_rd    = 1'b1;
        cmd.deg_sel   = DSEL_B;
        state_nxt     = S_E_CHK;
      end
      S_E_CHK: begin
        cmd.lat_deg_b = 1'b1;
        if (sts.fits) begin
          state_nxt = S_E_WRA;
        end else begin
          cmd.code_ld = 1'b1;
          cmd.code    = STAT_FULL;
          state_nxt   = S_RESP;
        end
      end
      S_E_WRA: begin
        cmd.edge_wr_a = 1'b1;
        state_nxt     = S_E_WRB;
      end
      S_E_WRB: begin
        cmd.edge_wr_b = 1'b1;
        cmd.code_ld   = 1'b1;
        cmd.code      = STAT_ADDED;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_W_DEG: begin
        cmd.lat_top_deg = 1'b1;
        state_nxt       = S_W_STEP;
      end
      S_W_STEP: begin
        if (sts.has_next) begin
          cmd.nbr_rd = 1'b1;
          state_nxt  = S_W_NBR;
        end else if (sts.depth_one) begin
          state_nxt = S_W_FLUSH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_W_POP;
        end
      end
      S_W_NBR: begin
        // descend only once the previous preorder vertex can leave
        if (!sts.push_ok) begin
          state_nxt = S_W_STEP;
        end else if (sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.deg_rd  = 1'b1;
          cmd.deg_sel = DSEL_X;
          state_nxt   = S_W_DEG;
        end
      end
      S_W_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_W_STEP;
      end
      S_W_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gdfw_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw_dpath
// Datapath: request registers, adjacency and degree memories, walk stack,
// visited marks and the result register.
// ----------------------------------------------------------------------------
module gdfw_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gdfw_pkg::gdfw_cmd_t             cmd,
  output gdfw_pkg::gdfw_sts_t             sts,
  input  logic                            in_req_type,
  input  logic [gdfw_pkg::VTX_W-1:0]      in_vertex_a,
  input  logic [gdfw_pkg::VTX_W-1:0]      in_vertex_b,
  input  logic                            cfg_we,
  input  logic [gdfw_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output gdfw_pkg::gdfw_status_t          out_status,
  output logic [gdfw_pkg::VTX_W-1:0]      out_vertex,
  output logic                            out_last
);
  import gdfw_pkg::*;

  // request and configuration
  logic                walk_r;
  logic [VTX_W-1:0]    a_r, b_r;
  logic [CFG_W-1:0]    cnt_r;
  logic [CFG_W-1:0]    cnt_eff;
  gdfw_status_t        code_r;

  // edge insertion
  logic [DEG_W-1:0]    deg_a_r, deg_b_r;
  logic [DEG_W-1:0]    deg_b_eff;
  logic                same_v;

  // degree memory
  logic [MAX_VERTICES-1:0] deg_vld_r;
  logic                    deg_rvld_r;
  logic [VTX_W-1:0]        deg_raddr, deg_waddr;
  logic [DEG_W-1:0]        deg_wdata, deg_rdata, deg_rd;
  logic                    deg_we;

  // neighbor memory
  logic [VTX_W+SLOT_W-1:0] nbr_waddr, nbr_raddr;
  logic [VTX_W-1:0]        nbr_wdata, nbr_x;
  logic                    nbr_we;

  // walk state
  logic [MAX_VERTICES-1:0] visited_r;
  logic [DEPTH_W-1:0]      depth_r, depth_m1, depth_m2;
  logic [VTX_W-1:0]        top_v_r, pend_r;
  logic [DEG_W-1:0]        top_i_r, top_deg_r;
  logic [STK_W-1:0]        stk_wdata, stk_rdata;

  // result register
  logic                    out_valid_r;
  gdfw_status_t            out_status_r;
  logic [VTX_W-1:0]        out_vertex_r;
  logic                    out_last_r;

  // counts above the vertex capacity act as the capacity
  assign cnt_eff = (cnt_r > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : cnt_r;

  assign same_v    = (a_r == b_r);
  assign deg_b_eff = same_v ? deg_a_r + DEG_W'(1) : deg_b_r;
  assign deg_rd    = deg_rvld_r ? deg_rdata : '0;
  assign depth_m1  = depth_r - DEPTH_W'(1);
  assign depth_m2  = depth_r - DEPTH_W'(2);

  // status to the controller
  always_comb begin
    sts.is_walk  = walk_r;
    sts.a_ok     = CFG_W'(a_r) < cnt_eff;
    sts.ab_ok    = (CFG_W'(a_r) < cnt_eff) && (CFG_W'(b_r) < cnt_eff);
    // self loop needs two slots, otherwise one in each list
    if (same_v) begin
      sts.fits = (DEG_W+1)'(deg_a_r) + (DEG_W+1)'(2) <= (DEG_W+1)'(MAX_DEGREE);
    end else begin
      sts.fits = (deg_a_r < DEG_W'(MAX_DEGREE)) && (deg_rd < DEG_W'(MAX_DEGREE));
    end
    sts.has_next  = top_i_r < top_deg_r;
    sts.push_ok   = !visited_r[nbr_x] && (depth_r < DEPTH_W'(MAX_VERTICES));
    sts.depth_one = depth_r == DEPTH_W'(1);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // degree memory ports
  always_comb begin
    case (cmd.deg_sel)
      DSEL_A:  deg_raddr = a_r;
      DSEL_B:  deg_raddr = b_r;
      DSEL_X:  deg_raddr = nbr_x;
      default: deg_raddr = a_r;
    endcase
    deg_we    = cmd.edge_wr_a || cmd.edge_wr_b;
    deg_waddr = cmd.edge_wr_b ? b_r : a_r;
    deg_wdata = cmd.edge_wr_b ? deg_b_eff + DEG_W'(1) : deg_a_r + DEG_W'(1);
  end

  gdfw_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_VERTICES)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (cmd.deg_rd),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  // neighbor memory ports, one list of MAX_DEGREE slots per vertex
  always_comb begin
    nbr_we    = cmd.edge_wr_a || cmd.edge_wr_b;
    nbr_waddr = cmd.edge_wr_b ? {b_r, deg_b_eff[SLOT_W-1:0]} : {a_r, deg_a_r[SLOT_W-1:0]};
    nbr_wdata = cmd.edge_wr_b ? a_r : b_r;
    nbr_raddr = {top_v_r, top_i_r[SLOT_W-1:0]};
  end

  gdfw_ram #(
    .WIDTH (VTX_W),
    .DEPTH (NBR_DEPTH)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .re    (cmd.nbr_rd),
    .raddr (nbr_raddr),
    .rdata (nbr_x)
  );

  // walk stack holds the frames below the top frame
  assign stk_wdata = {top_v_r, top_i_r, top_deg_r};

  gdfw_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_VERTICES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth_m1[VTX_W-1:0]),
    .wdata (stk_wdata),
    .re    (cmd.pop),
    .raddr (depth_m2[VTX_W-1:0]),
    .rdata (stk_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CFG_W'(MAX_VERTICES);
      deg_vld_r   <= '0;
      visited_r   <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      if (deg_we) begin
        deg_vld_r[deg_waddr] <= 1'b1;
      end
      // visited marks restart with only the start vertex
      if (cmd.walk_init) begin
        visited_r          <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_r;
      end else if (cmd.push) begin
        visited_r[nbr_x]   <= 1'b1;
      end
      if (cmd.walk_init) begin
        depth_r <= DEPTH_W'(1);
      end else if (cmd.push) begin
        depth_r <= depth_r + DEPTH_W'(1);
      end else if (cmd.pop || cmd.emit_final) begin
        depth_r <= depth_m1;
      end
      if (cmd.emit_status || cmd.push || cmd.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      walk_r <= in_req_type;
      a_r    <= in_vertex_a;
      b_r    <= in_vertex_b;
    end
    if (cmd.code_ld) begin
      code_r <= cmd.code;
    end
    if (cmd.deg_rd) begin
      deg_rvld_r <= deg_vld_r[deg_raddr];
    end
    if (cmd.lat_deg_a) begin
      deg_a_r <= deg_rd;
    end
    if (cmd.lat_deg_b) begin
      deg_b_r <= deg_rd;
    end
    // top frame of the walk
    if (cmd.walk_init) begin
      top_v_r <= a_r;
      top_i_r <= '0;
      pend_r  <= a_r;
    end else if (cmd.push) begin
      top_v_r <= nbr_x;
      top_i_r <= '0;
      pend_r  <= nbr_x;
    end else if (cmd.nbr_rd) begin
      top_i_r <= top_i_r + DEG_W'(1);
    end else if (cmd.pop_load) begin
      {top_v_r, top_i_r, top_deg_r} <= stk_rdata;
    end
    if (cmd.lat_top_deg) begin
      top_deg_r <= deg_rd;
    end
    // result payload, preorder vertex leaves one discovery late
    if (cmd.emit_status) begin
      out_status_r <= code_r;
      out_vertex_r <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.push || cmd.emit_final) begin
      out_status_r <= STAT_VISIT;
      out_vertex_r <= pend_r;
      out_last_r   <= cmd.emit_final;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;

endmodule

// ===== hw/rtl/gdfw_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfw_chk
// Port-level checks for the graph walker, bound to the top level.
// ----------------------------------------------------------------------------
module gdfw_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gdfw_pkg::STAT_W-1:0] out_status,
  input logic [gdfw_pkg::VTX_W-1:0]  out_vertex,
  input logic                        out_last
);
  import gdfw_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_vertex) && $stable(out_last))
    else $error("result changed while stalled");

  // only walk vertices may be non-final, everything else carries zero vertex
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_VISIT) |-> out_last && (out_vertex == '0))
    else $error("non-walk result not single or vertex nonzero");

  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind graph_depth_first_walk gdfw_chk u_gdfw_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_vertex (out_ch.visited_vertex),
  .out_last   (out_ch.last)
);
